FILE: rtl/pests_pkg.sv
// Package for the PES to transport stream packetizer.
// Holds the item types, packet layout constants and codes. No dependencies.
`default_nettype none

package pests_pkg;

  // Transport packet layout
  localparam int unsigned PKT_SIZE    = 188;
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned PAYLOAD_MAX = PKT_SIZE - HDR_BYTES;
  localparam int unsigned SPLIT_FILL  = PAYLOAD_MAX - 1;
  localparam int unsigned SPLIT_LEN   = PAYLOAD_MAX - 2;

  // Header and stuffing bytes
  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [7:0] AF_FLAGS   = 8'h00;

  // Adaptation field control nibble
  localparam logic [3:0] AFC_PAYLOAD = 4'h1;
  localparam logic [3:0] AFC_ADAPT   = 4'h3;

  // Start code 00 00 01 BD
  localparam logic [7:0] SC_BYTE0 = 8'h00;
  localparam logic [7:0] SC_BYTE1 = 8'h00;
  localparam logic [7:0] SC_BYTE2 = 8'h01;
  localparam logic [7:0] SC_BYTE3 = 8'hBD;

  // Request types
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // Configuration register indexes
  localparam logic REG_STREAM_PID = 1'b0;

  localparam logic [12:0] PID_RESET = 13'h1FFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } pests_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        packet_end;
    logic        last;
  } pests_out_t;

endpackage

`default_nettype wire

FILE: rtl/pes_to_ts_packetizer_unit.sv
// PES to transport stream packetizer: one byte item in, 64-bit packet words out.
// Each packet goes out as 23 words of 8 bytes and a last word of 4; for each word the byte
// lane gathers the bytes, then drains, then the output register is loaded. A split flush
// sends two such packets. The input stalls until the block is back in idle.
// Throughput is set by the single byte lane reading the payload store.
// Reset: synchronous; clears control state, PID to 8191, unit start flag set.
`default_nettype none

module pes_to_ts_packetizer_unit
  import pests_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire pests_in_t   in_item,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      pests_out_t  out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PUSH   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_GATHER = 3'd3;
  localparam logic [2:0] ST_WAITLD = 3'd4;

  // What follows a packet send
  localparam logic [1:0] AFT_PUSH   = 2'd0;
  localparam logic [1:0] AFT_CONT   = 2'd1;
  localparam logic [1:0] AFT_EOSEND = 2'd2;

  localparam logic [7:0] LAST_IDX = 8'(PKT_SIZE - 1);

  logic [2:0]  state;
  logic [12:0] pid;

  logic [7:0]  win [0:2];
  logic [1:0]  wfill;
  logic        is_eos;
  logic [7:0]  push_val;
  logic [7:0]  drain_buf [0:2];
  logic [1:0]  drain_cnt;
  logic [1:0]  drain_idx;

  logic [7:0]  store [0:PAYLOAD_MAX-1];
  logic [7:0]  fill;
  logic [3:0]  cc;
  logic        unit_start;
  logic [1:0]  aft;

  logic [7:0]  pk_len;
  logic [7:0]  pk_base;
  logic        pk_pusi;
  logic        split_pend;

  logic [7:0]  p;
  logic [2:0]  bcnt;
  logic        wd_end;
  logic        v1;
  logic        v1_mem;
  logic [7:0]  v1_const;
  logic [7:0]  rd_data;
  logic [63:0] acc;

  logic        match;
  logic        slot_free;
  logic        more_after;
  logic [7:0]  fill_inc;
  logic [7:0]  ss_len;
  logic        ss_split;
  logic [7:0]  thr;
  logic        is_mem;
  logic [7:0]  const_byte;
  logic [7:0]  rd_addr;
  logic        cfg_wr;

  assign in_stall  = (state != ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_STREAM_PID);
  assign prdata    = (paddr[2] == REG_STREAM_PID) ? {19'd0, pid} : 32'd0;
  assign slot_free = !out_valid || !out_stall;
  assign fill_inc  = fill + 8'd1;

  // Start code seen across the delay line and the new byte
  assign match = (win[0] == SC_BYTE0) && (win[1] == SC_BYTE1) &&
                 (win[2] == SC_BYTE2) && (in_item.data_byte == SC_BYTE3);

  // Flush of a 183-byte payload goes out as 182 + 1
  assign ss_split = (fill == 8'(SPLIT_FILL));
  assign ss_len   = ss_split ? 8'(SPLIT_LEN) : fill;

  // A full send during drain is followed by more results if bytes remain
  assign more_after = (aft == AFT_CONT) && is_eos && (drain_idx != drain_cnt);

  // Byte selection for packet byte p
  assign thr     = 8'(PKT_SIZE) - pk_len;
  assign rd_addr = p - thr + pk_base;

  always_comb begin
    is_mem     = 1'b0;
    const_byte = STUFF_BYTE;
    if (p < 8'(HDR_BYTES)) begin
      case (p[1:0])
        2'd0: const_byte = SYNC_BYTE;
        2'd1: const_byte = {1'b0, pk_pusi, 1'b0, pid[12:8]};
        2'd2: const_byte = pid[7:0];
        2'd3: const_byte = {(pk_len == 8'(PAYLOAD_MAX)) ? AFC_PAYLOAD : AFC_ADAPT, cc};
        default: const_byte = SYNC_BYTE;
      endcase
    end else if (p >= thr) begin
      is_mem = 1'b1;
    end else if (p == 8'(HDR_BYTES)) begin
      const_byte = 8'(PAYLOAD_MAX - 1) - pk_len;
    end else if (p == 8'(HDR_BYTES + 1)) begin
      const_byte = AF_FLAGS;
    end
  end

  // Payload store: write on push, registered read for the byte lane
  always_ff @(posedge clk) begin
    if (state == ST_PUSH) begin
      store[fill] <= push_val;
    end
    rd_data <= store[rd_addr];
  end

  // Byte lane: shift the selected byte into the word accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= (state == ST_GATHER);
    end
    v1_mem   <= is_mem;
    v1_const <= const_byte;
    if (v1) begin
      acc <= {acc[55:0], v1_mem ? rd_data : v1_const};
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pid <= PID_RESET;
    end else if (cfg_wr) begin
      pid <= pwdata[12:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wfill      <= 2'd0;
      win[0]     <= 8'd0;
      win[1]     <= 8'd0;
      win[2]     <= 8'd0;
      fill       <= 8'd0;
      cc         <= 4'd0;
      unit_start <= 1'b1;
      out_valid  <= 1'b0;
      is_eos     <= 1'b0;
      drain_cnt  <= 2'd0;
      drain_idx  <= 2'd0;
      split_pend <= 1'b0;
      aft        <= AFT_CONT;
      p          <= 8'd0;
      bcnt       <= 3'd0;
    end else begin
      // Release the output word once taken
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_item.req_type == REQ_EOS) begin
              // Hold the delay line for draining and clear it
              drain_buf[0] <= win[0];
              drain_buf[1] <= win[1];
              drain_buf[2] <= win[2];
              drain_cnt    <= wfill;
              drain_idx    <= 2'd0;
              win[0]       <= 8'd0;
              win[1]       <= 8'd0;
              win[2]       <= 8'd0;
              wfill        <= 2'd0;
              is_eos       <= 1'b1;
              state        <= ST_DRAIN;
            end else if (wfill != 2'd3) begin
              win[wfill] <= in_item.data_byte;
              wfill      <= wfill + 2'd1;
            end else begin
              // Advance the delay line; the oldest byte goes to the store
              is_eos   <= 1'b0;
              push_val <= win[0];
              win[0]   <= win[1];
              win[1]   <= win[2];
              win[2]   <= in_item.data_byte;
              if (match && (fill != 8'd0)) begin
                pk_len     <= ss_len;
                pk_base    <= 8'd0;
                pk_pusi    <= unit_start;
                split_pend <= ss_split;
                p          <= 8'd0;
                bcnt       <= 3'd0;
                aft        <= AFT_PUSH;
                state      <= ST_GATHER;
              end else begin
                if (match) begin
                  unit_start <= 1'b1;
                end
                state <= ST_PUSH;
              end
            end
          end
        end

        ST_PUSH: begin
          fill <= fill_inc;
          if (fill_inc == 8'(PAYLOAD_MAX)) begin
            pk_len     <= 8'(PAYLOAD_MAX);
            pk_base    <= 8'd0;
            pk_pusi    <= unit_start;
            split_pend <= 1'b0;
            p          <= 8'd0;
            bcnt       <= 3'd0;
            aft        <= AFT_CONT;
            state      <= ST_GATHER;
          end else begin
            state <= is_eos ? ST_DRAIN : ST_IDLE;
          end
        end

        ST_DRAIN: begin
          if (drain_idx != drain_cnt) begin
            push_val  <= drain_buf[drain_idx];
            drain_idx <= drain_idx + 2'd1;
            state     <= ST_PUSH;
          end else if (fill != 8'd0) begin
            pk_len     <= ss_len;
            pk_base    <= 8'd0;
            pk_pusi    <= unit_start;
            split_pend <= ss_split;
            p          <= 8'd0;
            bcnt       <= 3'd0;
            aft        <= AFT_EOSEND;
            state      <= ST_GATHER;
          end else begin
            unit_start <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        ST_GATHER: begin
          // Issue one packet byte a cycle until the word is complete
          if (p == LAST_IDX) begin
            wd_end <= 1'b1;
            p      <= 8'd0;
            bcnt   <= 3'd0;
            state  <= ST_WAITLD;
          end else begin
            p    <= p + 8'd1;
            bcnt <= bcnt + 3'd1;
            if (bcnt == 3'd7) begin
              wd_end <= 1'b0;
              state  <= ST_WAITLD;
            end
          end
        end

        ST_WAITLD: begin
          if (!v1 && slot_free) begin
            out_valid           <= 1'b1;
            out_item.out_word   <= wd_end ? {acc[31:0], 32'd0} : acc;
            out_item.byte_count <= wd_end ? 4'd4 : 4'd8;
            out_item.packet_end <= wd_end;
            out_item.last       <= wd_end && !split_pend && !more_after;
            if (!wd_end) begin
              state <= ST_GATHER;
            end else begin
              cc <= cc + 4'd1;
              if (split_pend) begin
                // Second packet of a split: last stored byte, no unit start
                pk_len     <= 8'd1;
                pk_base    <= 8'(SPLIT_LEN);
                pk_pusi    <= 1'b0;
                split_pend <= 1'b0;
                state      <= ST_GATHER;
              end else begin
                fill       <= 8'd0;
                unit_start <= 1'b0;
                case (aft)
                  AFT_PUSH: begin
                    unit_start <= 1'b1;
                    state      <= ST_PUSH;
                  end
                  AFT_EOSEND: begin
                    unit_start <= 1'b1;
                    state      <= ST_IDLE;
                  end
                  default: begin
                    state <= is_eos ? ST_DRAIN : ST_IDLE;
                  end
                endcase
              end
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/pes_to_ts_packetizer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PES to transport stream packetizer.
// Drives byte and end-of-stream items and the PID register, and checks every packet word
// against a built-in packet predictor. Depends on pests_pkg and pes_to_ts_packetizer_unit.

module pes_to_ts_packetizer_unit_tb;
  import pests_pkg::*;

  localparam int WORDS_PER_PKT = (PKT_SIZE + 7) / 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET   = 450;
  localparam int REPORT_MAX    = 10;

  // Register map: index 0 holds the PID, the slot above it is unmapped
  localparam logic [2:0] ADDR_PID   = {REG_STREAM_PID, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'b100;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    pests_in_t   item;
    logic [2:0]  addr;
    logic [12:0] pid;
    logic        typed;
    logic [63:0] word0;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  pests_in_t   in_item;
  logic        out_valid;
  logic        out_stall;
  pests_out_t  out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Packet predictor state
  logic [7:0]  delay_q [3];
  int          delay_cnt;
  logic [7:0]  pay_buf [PAYLOAD_MAX];
  int          pay_cnt;
  logic [3:0]  cc;
  logic        start_pend;
  logic [12:0] pid_cur;

  pests_out_t  exp_words [$];
  int          mismatch_cnt;
  int          items_sent;
  int          in_idle_pct;
  int          out_stall_pct;

  // Directed items: start-up, start codes with and without buffered data, PID changes
  stim_row_t dir_rows [23] = '{
    '{ROW_ITEM, '{REQ_EOS,  8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_EOS,  8'h00}, ADDR_PID,   13'h0000, 1'b1, 64'h475FFF30B600FFFF},
    '{ROW_ITEM, '{REQ_DATA, 8'hFF}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h01}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'hBD}, ADDR_PID,   13'h0000, 1'b1, 64'h475FFF31B600FFFF},
    '{ROW_ITEM, '{REQ_EOS,  8'hFF}, ADDR_PID,   13'h0000, 1'b1, 64'h475FFF32B300FFFF},
    '{ROW_ITEM, '{REQ_EOS,  8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h01}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'hBD}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_EOS,  8'h00}, ADDR_PID,   13'h0000, 1'b1, 64'h475FFF33B300FFFF},
    '{ROW_REG,  '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h80}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_EOS,  8'h00}, ADDR_PID,   13'h0000, 1'b1, 64'h47400034B600FFFF},
    '{ROW_REG,  '{REQ_DATA, 8'h00}, ADDR_SPARE, 13'h0155, 1'b0, 64'h0},
    '{ROW_REG,  '{REQ_DATA, 8'h00}, ADDR_PID,   13'h0A5A, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_DATA, 8'h7F}, ADDR_PID,   13'h0000, 1'b0, 64'h0},
    '{ROW_ITEM, '{REQ_EOS,  8'h00}, ADDR_PID,   13'h0000, 1'b1, 64'h474A5A35B600FFFF},
    '{ROW_REG,  '{REQ_DATA, 8'h00}, ADDR_PID,   13'h1FFF, 1'b0, 64'h0}
  };

  pes_to_ts_packetizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Build one transport packet from the payload buffer and queue its 24 words
  function automatic void emit_packet(int base, int len, logic pusi);
    logic [7:0] pkt [PKT_SIZE];
    pests_out_t w;
    int idx;
    pkt[0] = SYNC_BYTE;
    pkt[1] = {1'b0, pusi, 1'b0, pid_cur[12:8]};
    pkt[2] = pid_cur[7:0];
    if (len == PAYLOAD_MAX) begin
      pkt[3] = {AFC_PAYLOAD, cc};
      for (int i = 0; i < PAYLOAD_MAX; i++) pkt[HDR_BYTES + i] = pay_buf[base + i];
    end else begin
      pkt[3] = {AFC_ADAPT, cc};
      pkt[4] = 8'(PAYLOAD_MAX - 1 - len);
      pkt[5] = AF_FLAGS;
      for (int i = HDR_BYTES + 2; i < PKT_SIZE - len; i++) pkt[i] = STUFF_BYTE;
      for (int i = 0; i < len; i++) pkt[PKT_SIZE - len + i] = pay_buf[base + i];
    end
    cc = cc + 4'd1;
    for (int wi = 0; wi < WORDS_PER_PKT; wi++) begin
      w = '0;
      for (int b = 0; b < 8; b++) begin
        idx = wi * 8 + b;
        if (idx < PKT_SIZE) begin
          w.out_word[63 - 8 * b -: 8] = pkt[idx];
          w.byte_count = w.byte_count + 4'd1;
        end
      end
      w.packet_end = (wi == WORDS_PER_PKT - 1);
      exp_words.push_back(w);
    end
  endfunction

  // Send whatever payload is buffered; a 183-byte payload goes out as 182 + 1
  function automatic void flush_payload();
    if (pay_cnt == 0) return;
    if (pay_cnt == SPLIT_FILL) begin
      emit_packet(0, SPLIT_LEN, start_pend);
      emit_packet(SPLIT_LEN, 1, 1'b0);
    end else begin
      emit_packet(0, pay_cnt, start_pend);
    end
    pay_cnt    = 0;
    start_pend = 1'b0;
  endfunction

  function automatic void push_payload(logic [7:0] b);
    if (pay_cnt < PAYLOAD_MAX) begin
      pay_buf[pay_cnt] = b;
      pay_cnt++;
    end
    if (pay_cnt >= PAYLOAD_MAX) flush_payload();
  endfunction

  // Advance the predictor by one item; returns the number of words it queued
  function automatic int predict_packets(pests_in_t it);
    int n_prior;
    n_prior = exp_words.size();
    if (it.req_type == REQ_DATA) begin
      if (delay_cnt >= 3) begin
        if (delay_q[0] == SC_BYTE0 && delay_q[1] == SC_BYTE1 &&
            delay_q[2] == SC_BYTE2 && it.data_byte == SC_BYTE3) begin
          flush_payload();
          start_pend = 1'b1;
        end
        push_payload(delay_q[0]);
        delay_q[0] = delay_q[1];
        delay_q[1] = delay_q[2];
        delay_q[2] = it.data_byte;
      end else begin
        delay_q[delay_cnt] = it.data_byte;
        delay_cnt++;
      end
    end else begin
      // Drain the delay line, flush and re-arm unit start
      for (int i = 0; i < delay_cnt; i++) push_payload(delay_q[i]);
      delay_cnt = 0;
      delay_q   = '{default: 8'h00};
      flush_payload();
      start_pend = 1'b1;
    end
    if (exp_words.size() > n_prior) exp_words[exp_words.size() - 1].last = 1'b1;
    return exp_words.size() - n_prior;
  endfunction

  // Byte source: biased towards start-code bytes unless asked for plain data
  function automatic logic [7:0] pes_byte(bit biased);
    int r;
    r = $urandom_range(99);
    if (!biased || r >= 45) return 8'($urandom());
    if (r < 25) return SC_BYTE0;
    if (r < 35) return SC_BYTE2;
    return SC_BYTE3;
  endfunction

  // Offer one item, hold it until accepted, then predict its packets
  task automatic send_item(pests_in_t it, logic typed = 1'b0, logic [63:0] word0 = '0);
    int n;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    n = predict_packets(it);
    if (typed && n > 0) exp_words[exp_words.size() - n].out_word = word0;
    items_sent++;
  endtask

  task automatic send_data(logic [7:0] b);
    send_item('{REQ_DATA, b});
  endtask

  // Hold off the source until every queued word has come out, then let it settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One transfer: setup, access, then the bus goes idle
  task automatic apb_xfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_pid_readback();
    logic [31:0] rd;
    apb_xfer(1'b0, ADDR_PID, '0, rd);
    if (rd !== {19'b0, pid_cur}) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("PID readback: expected %h, got %h", {19'b0, pid_cur}, rd);
    end
  endtask

  // Register writes only once the block has gone quiet
  task automatic reg_update(logic [2:0] addr, logic [31:0] wdata);
    logic [31:0] rd;
    wait_idle();
    apb_xfer(1'b1, addr, wdata, rd);
    if (addr == ADDR_PID) pid_cur = wdata[12:0];
    check_pid_readback();
  endtask

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each accepted word with the oldest expected one
  always @(posedge clk) begin : word_check
    pests_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected word %h count %0d end %b last %b", out_item.out_word,
                   out_item.byte_count, out_item.packet_end, out_item.last);
      end else begin
        want = exp_words.pop_front();
        if (out_item.out_word !== want.out_word || out_item.byte_count !== want.byte_count ||
            out_item.packet_end !== want.packet_end || out_item.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("word mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                     want.out_word, want.byte_count, want.packet_end, want.last,
                     out_item.out_word, out_item.byte_count, out_item.packet_end,
                     out_item.last);
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int seq_no;
    int kind;
    int len;
    logic [31:0] wdata;
    logic [7:0] b2;
    logic [7:0] b3;
    pests_in_t noise;

    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    delay_q    = '{default: 8'h00};
    delay_cnt  = 0;
    pay_cnt    = 0;
    cc         = '0;
    start_pend = 1'b1;
    pid_cur    = PID_RESET;
    mismatch_cnt  = 0;
    items_sent    = 0;
    in_idle_pct   = 36;
    out_stall_pct = 72;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_pid_readback();

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        reg_update(dir_rows[i].addr, {19'b0, dir_rows[i].pid});
      else
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].word0);
    end

    // Random PES-like streams; first a split flush and a mid-stream full packet
    seq_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < 150) begin
        in_idle_pct   = 36;
        out_stall_pct = 72;
      end else if (items_sent < 300) begin
        in_idle_pct   = 72;
        out_stall_pct = 36;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end

      if (seq_no > 1 && seq_no % 6 == 0) begin
        wdata = $urandom();
        case ($urandom_range(3))
          0: wdata[12:0] = '0;
          1: wdata[12:0] = PID_RESET;
          default: ;
        endcase
        reg_update(($urandom_range(4) == 0) ? ADDR_SPARE : ADDR_PID, wdata);
      end else if (seq_no % 9 == 4) begin
        wait_idle();
      end

      if (seq_no < 2) begin
        kind = 14;
        len  = (seq_no == 0) ? SPLIT_FILL : PAYLOAD_MAX + 3;
      end else begin
        kind = $urandom_range(19);
        len  = (kind == 14) ? $urandom_range(170, 190) : $urandom_range(40);
      end

      if (kind <= 14) begin
        // Well-formed: optional start code, body, usually an end of stream
        if (seq_no >= 2 && $urandom_range(1)) begin
          send_data(SC_BYTE0);
          send_data(SC_BYTE1);
          send_data(SC_BYTE2);
          send_data(SC_BYTE3);
        end
        repeat (len) send_data(pes_byte(seq_no >= 2));
        if (kind == 14 || $urandom_range(1)) send_item('{REQ_EOS, 8'($urandom())});
      end else if (kind <= 17) begin
        // Noise, with stray end-of-stream items
        repeat ($urandom_range(1, 8)) begin
          noise.req_type  = ($urandom_range(3) == 0) ? REQ_EOS : REQ_DATA;
          noise.data_byte = 8'($urandom());
          send_item(noise);
        end
      end else begin
        // Near-miss start codes
        b2 = $urandom_range(1) ? SC_BYTE2 : pes_byte(1'b1);
        b3 = 8'($urandom());
        if (b2 == SC_BYTE2 && b3 == SC_BYTE3) b3 = b3 ^ 8'h01;
        if (b2 != SC_BYTE2) b3 = SC_BYTE3;
        send_data(SC_BYTE0);
        send_data(SC_BYTE1);
        send_data(b2);
        send_data(b3);
      end
      seq_no++;
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (exp_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && exp_words.size() == 0) begin
      $display("pes_to_ts_packetizer_unit verification clean");
    end else begin
      $display("pes_to_ts_packetizer_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("pes_to_ts_packetizer_unit verification failed");
    $finish;
  end

endmodule
